// ===== rtl/rpf_pkg.sv =====
package rpf_pkg;

    localparam int MAX_PAYLOAD = 66;
    localparam int BUF_SIZE    = MAX_PAYLOAD + 5;
    localparam int AW          = $clog2(BUF_SIZE);
    localparam int FW          = $clog2(BUF_SIZE + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  PREAMBLE = 8'hAA;
    localparam logic [7:0]  SYNC     = 8'h2D;
    localparam logic [4:0]  NODE_ALL = 5'h1F;
    localparam logic [7:0]  GROUP_RESET = 8'd212;

    localparam logic [AW-1:0] ADDR_GROUP  = AW'(0);
    localparam logic [AW-1:0] ADDR_HEADER = AW'(1);
    localparam logic [AW-1:0] ADDR_LENGTH = AW'(2);
    localparam logic [AW-1:0] ADDR_DATA   = AW'(3);

    // request codes
    localparam logic [2:0] REQ_EVENT = 3'd0;
    localparam logic [2:0] REQ_LOAD  = 3'd1;
    localparam logic [2:0] REQ_SEND  = 3'd2;
    localparam logic [2:0] REQ_RXON  = 3'd3;
    localparam logic [2:0] REQ_POLL  = 3'd4;
    localparam logic [2:0] REQ_CLAIM = 3'd5;
    localparam logic [2:0] REQ_READ  = 3'd6;

    // radio commands
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_IDLE = 2'd2;
    localparam logic [1:0] CMD_TX   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE  = 2'd0;
    localparam logic [1:0] CFG_GROUP = 2'd1;

    typedef enum logic [11:0] {
        PH_IDLE = 12'h001,
        PH_RECV = 12'h002,
        PH_PRE1 = 12'h004,
        PH_PRE2 = 12'h008,
        PH_PRE3 = 12'h010,
        PH_SYN1 = 12'h020,
        PH_SYN2 = 12'h040,
        PH_BODY = 12'h080,
        PH_CRC1 = 12'h100,
        PH_CRC2 = 12'h200,
        PH_TAIL = 12'h400,
        PH_DONE = 12'h800
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WR   = 5'b00010,
        S_RD   = 5'b00100,
        S_CRC  = 5'b01000,
        S_FIN  = 5'b10000
    } t_seq;

    function automatic logic [15:0] crc_bit(input logic [15:0] c);
        return c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

    // receive ends at length + 5 bytes or a full buffer
    function automatic logic rx_done(input logic [FW-1:0] fill, input logic [7:0] len);
        logic [9:0] f;
        f = 10'(fill);
        return (f >= 10'(len) + 10'd5) || (f >= 10'(BUF_SIZE));
    endfunction

endpackage

// ===== rtl/rpf_ram.sv =====
module rpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/radio_packet_framer_crc16_unit.sv =====
// Packet framer for a byte radio with CRC-16 (reflected 0xA001). The packet
// buffer (group, header, length, payload, CRC) sits in a single-port-write
// RAM with a registered read; header and length are also shadowed in flops.
// Each transaction yields exactly one result. A radio byte event that stores
// a received byte or sends a payload byte passes a RAM write or read and then
// a bit-serial CRC step before the next request is taken; start send also runs
// the CRC step after its RAM write, and start receive, and a poll that restarts
// receive, run it with a nonzero group; a buffer read within the buffer passes
// through the registered RAM read; all other requests go straight to the result.
// A new request is accepted while the previous result still waits in the output
// register; its own result then waits until the output register is taken.
module radio_packet_framer_crc16_unit
    import rpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_byte_in,
    input  logic [6:0]  i_index,
    input  logic [7:0]  i_header,
    input  logic [6:0]  i_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic [1:0]  o_radio_cmd,
    output logic        o_flag,
    output logic [15:0] o_crc_value,
    output logic [7:0]  o_read_byte,
    output logic [6:0]  o_fill_count
);

    t_seq            r_seq, n_seq;
    t_phase          r_phase, n_phase;
    logic [FW-1:0]   r_fill, n_fill;
    logic [15:0]     r_crc, n_crc;
    logic [FW-1:0]   r_tx_pos, n_tx_pos;
    logic [7:0]      r_len, r_hdr;
    logic [4:0]      r_node;
    logic [7:0]      r_group;
    logic [2:0]      r_bit, n_bit;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    logic [7:0]      r_wr_data, n_wr_data;
    logic            r_wr_rx, n_wr_rx;
    logic            r_chk, n_chk;
    logic            r_rd_body, n_rd_body;
    logic [7:0]      r_txb, n_txb;
    logic            r_txv, n_txv;
    logic [1:0]      r_cmd, n_cmd;
    logic            r_flg, n_flg;
    logic [7:0]      r_rdb, n_rdb;
    logic            r_out_valid, n_out_valid;
    logic            out_load;

    logic [7:0]      r_o_txb, r_o_rdb;
    logic            r_o_txv, r_o_flg;
    logic [1:0]      r_o_cmd;
    logic [15:0]     r_o_crc;
    logic [FW-1:0]   r_o_fill;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_wdata, ram_rdata;

    rpf_ram #(
        .WIDTH(8),
        .DEPTH(BUF_SIZE)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_ready = (r_seq == S_IDLE);

    always_comb begin
        logic          start_rx;
        logic [7:0]    len_sat;
        logic [FW-1:0] pos_inc;
        start_rx    = 1'b0;
        len_sat     = (8'(i_length) > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : 8'(i_length);
        pos_inc     = r_tx_pos + FW'(1);
        n_seq       = r_seq;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_crc       = r_crc;
        n_tx_pos    = r_tx_pos;
        n_bit       = r_bit;
        n_wr_addr   = r_wr_addr;
        n_wr_data   = r_wr_data;
        n_wr_rx     = r_wr_rx;
        n_chk       = r_chk;
        n_rd_body   = r_rd_body;
        n_txb       = r_txb;
        n_txv       = r_txv;
        n_cmd       = r_cmd;
        n_flg       = r_flg;
        n_rdb       = r_rdb;
        n_out_valid = r_out_valid && !i_ready;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_addr;
        ram_wdata   = r_wr_data;
        ram_raddr   = AW'(r_tx_pos);

        unique case (r_seq)
            S_IDLE: begin
                if (i_valid) begin
                    n_txb     = 8'h00;
                    n_txv     = 1'b0;
                    n_cmd     = CMD_NONE;
                    n_flg     = 1'b0;
                    n_rdb     = 8'h00;
                    n_chk     = 1'b0;
                    n_rd_body = 1'b0;
                    n_seq     = S_FIN;
                    unique case (i_req_type)
                        REQ_EVENT: begin
                            if (r_phase == PH_RECV) begin
                                if (!rx_done(r_fill, r_len)) begin
                                    n_wr_rx   = 1'b1;
                                    n_wr_data = i_byte_in;
                                    n_chk     = 1'b1;
                                    n_seq     = S_WR;
                                    if (r_fill == '0 && r_group != 8'h00) begin
                                        // group byte goes in front of the first byte
                                        ram_we    = 1'b1;
                                        ram_waddr = ADDR_GROUP;
                                        ram_wdata = r_group;
                                        n_fill    = FW'(1);
                                        n_wr_addr = ADDR_HEADER;
                                    end else begin
                                        n_wr_addr = AW'(r_fill);
                                    end
                                end
                            end else if (r_phase != PH_IDLE) begin
                                n_txv = 1'b1;
                                n_txb = PREAMBLE;
                                unique case (r_phase)
                                    PH_PRE1: n_phase = PH_PRE2;
                                    PH_PRE2: n_phase = PH_PRE3;
                                    PH_PRE3: n_phase = PH_SYN1;
                                    PH_SYN1: begin
                                        n_txb   = SYNC;
                                        n_phase = PH_SYN2;
                                    end
                                    PH_SYN2: begin
                                        n_txb    = r_group;
                                        n_phase  = PH_BODY;
                                        n_tx_pos = FW'(1);
                                    end
                                    PH_BODY: begin
                                        n_rd_body = 1'b1;
                                        n_seq     = S_RD;
                                    end
                                    PH_CRC1: begin
                                        n_txb   = r_crc[7:0];
                                        n_phase = PH_CRC2;
                                    end
                                    PH_CRC2: begin
                                        n_txb   = r_crc[15:8];
                                        n_phase = PH_TAIL;
                                    end
                                    PH_TAIL: n_phase = PH_DONE;
                                    PH_DONE: begin
                                        n_cmd   = CMD_IDLE;
                                        n_phase = PH_IDLE;
                                    end
                                    default: n_phase = r_phase;
                                endcase
                            end
                        end
                        REQ_LOAD: begin
                            if (8'(i_index) < 8'(MAX_PAYLOAD)) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(i_index) + ADDR_DATA;
                                ram_wdata = i_byte_in;
                            end
                        end
                        REQ_SEND: begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_LENGTH;
                            ram_wdata = len_sat;
                            n_wr_addr = ADDR_HEADER;
                            n_wr_data = i_header[6] ? i_header : {i_header[7:5], r_node};
                            n_wr_rx   = 1'b0;
                            n_phase   = PH_PRE1;
                            n_cmd     = CMD_TX;
                            n_seq     = S_WR;
                        end
                        REQ_RXON: start_rx = 1'b1;
                        REQ_POLL: begin
                            if (r_phase == PH_RECV && rx_done(r_fill, r_len)) begin
                                n_phase = PH_IDLE;
                                if (r_len > 8'(MAX_PAYLOAD)) begin
                                    n_crc = 16'h0001;
                                end
                                if (!r_hdr[6] || r_node == NODE_ALL || r_hdr[4:0] == r_node) begin
                                    n_flg = 1'b1;
                                end else begin
                                    start_rx = 1'b1;
                                end
                            end else if (r_phase == PH_IDLE) begin
                                start_rx = 1'b1;
                            end
                        end
                        REQ_CLAIM: begin
                            if (r_phase == PH_RECV && r_fill == '0) begin
                                n_cmd   = CMD_IDLE;
                                n_phase = PH_IDLE;
                                n_flg   = 1'b1;
                            end
                        end
                        REQ_READ: begin
                            if (8'(i_index) < 8'(BUF_SIZE)) begin
                                ram_raddr = AW'(i_index);
                                n_seq     = S_RD;
                            end
                        end
                        default: n_seq = S_FIN;
                    endcase
                    if (start_rx) begin
                        n_fill    = '0;
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_LENGTH;
                        ram_wdata = 8'h00;
                        n_phase   = PH_RECV;
                        n_cmd     = CMD_RX;
                        if (r_group != 8'h00) begin
                            n_crc = CRC_INIT ^ {8'h00, r_group};
                            n_bit = 3'd0;
                            n_seq = S_CRC;
                        end else begin
                            n_crc = CRC_INIT;
                        end
                    end
                end
            end
            S_WR: begin
                ram_we = 1'b1;
                if (r_wr_rx) begin
                    n_fill = r_fill + FW'(1);
                    n_crc  = r_crc ^ {8'h00, r_wr_data};
                end else begin
                    n_crc = CRC_INIT ^ {8'h00, r_group};
                end
                n_bit = 3'd0;
                n_seq = S_CRC;
            end
            S_RD: begin
                if (r_rd_body) begin
                    n_txb    = ram_rdata;
                    n_crc    = r_crc ^ {8'h00, ram_rdata};
                    n_tx_pos = pos_inc;
                    if ((10'(pos_inc) > 10'(r_len) + 10'd2) || (10'(pos_inc) >= 10'(BUF_SIZE))) begin
                        n_phase = PH_CRC1;
                    end
                    n_bit = 3'd0;
                    n_seq = S_CRC;
                end else begin
                    n_rdb = ram_rdata;
                    n_seq = S_FIN;
                end
            end
            S_CRC: begin
                n_crc = crc_bit(r_crc);
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_seq = S_FIN;
                    if (r_chk && rx_done(r_fill, r_len)) begin
                        n_cmd = CMD_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_seq       = S_IDLE;
                end
            end
            default: n_seq = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_fill      <= '0;
            r_crc       <= CRC_INIT;
            r_tx_pos    <= '0;
            r_node      <= 5'd0;
            r_group     <= GROUP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_crc       <= n_crc;
            r_tx_pos    <= n_tx_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_NODE) begin
                    r_node <= i_cfg_data[4:0];
                end else if (i_cfg_idx == CFG_GROUP) begin
                    r_group <= i_cfg_data;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_bit     <= n_bit;
        r_wr_addr <= n_wr_addr;
        r_wr_data <= n_wr_data;
        r_wr_rx   <= n_wr_rx;
        r_chk     <= n_chk;
        r_rd_body <= n_rd_body;
        r_txb     <= n_txb;
        r_txv     <= n_txv;
        r_cmd     <= n_cmd;
        r_flg     <= n_flg;
        r_rdb     <= n_rdb;
        // shadow copies of header and length entries
        if (ram_we && ram_waddr == ADDR_HEADER) begin
            r_hdr <= ram_wdata;
        end
        if (ram_we && ram_waddr == ADDR_LENGTH) begin
            r_len <= ram_wdata;
        end
        if (out_load) begin
            r_o_txb  <= r_txb;
            r_o_txv  <= r_txv;
            r_o_cmd  <= r_cmd;
            r_o_flg  <= r_flg;
            r_o_crc  <= r_crc;
            r_o_rdb  <= r_rdb;
            r_o_fill <= r_fill;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tx_byte    = r_o_txb;
    assign o_tx_valid   = r_o_txv;
    assign o_radio_cmd  = r_o_cmd;
    assign o_flag       = r_o_flg;
    assign o_crc_value  = r_o_crc;
    assign o_read_byte  = r_o_rdb;
    assign o_fill_count = 7'(r_o_fill);

endmodule

// ===== rtl/rpf_checker.sv =====
module rpf_checker
    import rpf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_tx_byte,
    input logic        o_tx_valid,
    input logic [1:0]  o_radio_cmd,
    input logic        o_flag,
    input logic [15:0] o_crc_value,
    input logic [7:0]  o_read_byte,
    input logic [6:0]  o_fill_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_crc_value) && $stable(o_tx_byte)
            && $stable(o_fill_count) && $stable(o_radio_cmd))
        else $error("stalled result changed");

    // the block is busy in the cycle after it accepts a transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted back to back");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_byte == 8'h00)
        else $error("tx byte without tx valid");

    // a granted flag never comes with a transmitted byte, transmit command or read byte
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flag |-> !o_tx_valid && o_radio_cmd != CMD_TX && o_read_byte == 8'h00)
        else $error("flag together with transmit or read");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 8'(o_fill_count) <= 8'(BUF_SIZE))
        else $error("fill count beyond buffer");

endmodule

bind radio_packet_framer_crc16_unit rpf_checker u_rpf_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rpf_pkg::*;

    localparam logic [2:0] REQ_NOP = 3'd7;

    typedef struct packed {
        logic [2:0] req;
        logic [7:0] din;
        logic [6:0] idx;
        logic [7:0] hdr;
        logic [6:0] len;
    } frame_req_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic [1:0]  cmd;
        logic        flag;
        logic [15:0] crc;
        logic [7:0]  rd_byte;
        logic [6:0]  fill;
    } frame_res_t;

    typedef struct packed {
        frame_req_t it;
        logic       typed;
        frame_res_t want;
    } dir_row_t;

    // nothing touched since reset: crc at its initial value, buffer empty
    localparam frame_res_t RES_RESET = '{8'h00, 1'b0, CMD_NONE, 1'b0, 16'hFFFF, 8'h00, 7'd0};

    localparam dir_row_t DIR_ROWS [21] = '{
        '{'{REQ_EVENT, 8'h00, 7'd0,   8'h00, 7'd0},   1'b1, RES_RESET},
        '{'{REQ_NOP,   8'hFF, 7'd127, 8'hFF, 7'd127}, 1'b1, RES_RESET},
        '{'{REQ_CLAIM, 8'h00, 7'd0,   8'h00, 7'd0},   1'b1, RES_RESET},
        '{'{REQ_READ,  8'h00, 7'd127, 8'h00, 7'd0},   1'b1, RES_RESET},
        '{'{REQ_LOAD,  8'hAA, 7'd100, 8'h00, 7'd0},   1'b1, RES_RESET},
        '{'{REQ_LOAD,  8'hFF, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_LOAD,  8'h00, 7'd65,  8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_SEND,  8'h00, 7'd0,   8'hFF, 7'd127}, 1'b0, '0},
        '{'{REQ_READ,  8'h00, 7'd2,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_POLL,  8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_EVENT, 8'h55, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_RXON,  8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_EVENT, 8'h45, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_EVENT, 8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_POLL,  8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_EVENT, 8'hFF, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_EVENT, 8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_EVENT, 8'h7E, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_POLL,  8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_CLAIM, 8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0},
        '{'{REQ_READ,  8'h00, 7'd0,   8'h00, 7'd0},   1'b0, '0}
    };

    localparam logic [4:0] NODE_PLAN  [7] = '{5'd5, 5'd31, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0};
    localparam logic [7:0] GROUP_PLAN [7] = '{8'd212, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd1};
    localparam int ITEMS_PER_PHASE = 215;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [7:0]  i_byte_in = '0;
    logic [6:0]  i_index = '0;
    logic [7:0]  i_header = '0;
    logic [6:0]  i_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_tx_valid;
    logic [1:0]  o_radio_cmd;
    logic        o_flag;
    logic [15:0] o_crc_value;
    logic [7:0]  o_read_byte;
    logic [6:0]  o_fill_count;

    radio_packet_framer_crc16_unit uut (.*);

    // framer state as seen by the predictor
    logic [4:0]  fr_node;
    logic [7:0]  fr_group;
    t_phase      fr_phase;
    int          fr_fill;
    logic [15:0] fr_crc;
    int          fr_txpos;
    logic [7:0]  fr_pkt [BUF_SIZE];
    bit          fr_wr  [BUF_SIZE];

    frame_res_t radio_out_q [$];
    int         n_fail = 0;
    int         n_acted = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        return v;
    endfunction

    function automatic bit rx_full();
        return fr_fill >= int'(fr_pkt[2]) + 5 || fr_fill >= BUF_SIZE;
    endfunction

    function automatic void open_receive();
        fr_fill = 0;
        fr_pkt[2] = 8'h00;
        fr_wr[2] = 1'b1;
        fr_crc = (fr_group != 8'h00) ? crc16_byte(16'hFFFF, fr_group) : 16'hFFFF;
        fr_phase = PH_RECV;
    endfunction

    function automatic void rx_store(input logic [7:0] b);
        fr_pkt[fr_fill] = b;
        fr_wr[fr_fill] = 1'b1;
        fr_fill++;
    endfunction

    // acted is cleared when the block leaves its state untouched; reads always count as acted
    function automatic frame_res_t calc_framer_result(input frame_req_t it, output bit acted);
        frame_res_t r;
        logic [6:0] ln;
        logic [7:0] h;
        r = '0;
        acted = 1'b1;
        case (it.req)
            REQ_EVENT: begin
                if (fr_phase == PH_RECV) begin
                    if (!rx_full()) begin
                        if (fr_fill == 0 && fr_group != 8'h00)
                            rx_store(fr_group);
                        rx_store(it.din);
                        fr_crc = crc16_byte(fr_crc, it.din);
                        if (rx_full())
                            r.cmd = CMD_IDLE;
                    end else begin
                        acted = 1'b0;
                    end
                end else if (fr_phase == PH_IDLE) begin
                    acted = 1'b0;
                end else begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = PREAMBLE;
                    case (fr_phase)
                        PH_PRE1: fr_phase = PH_PRE2;
                        PH_PRE2: fr_phase = PH_PRE3;
                        PH_PRE3: fr_phase = PH_SYN1;
                        PH_SYN1: begin
                            r.tx_byte = SYNC;
                            fr_phase = PH_SYN2;
                        end
                        PH_SYN2: begin
                            r.tx_byte = fr_group;
                            fr_phase = PH_BODY;
                            fr_txpos = 1;
                        end
                        PH_BODY: begin
                            r.tx_byte = (fr_txpos < BUF_SIZE) ? fr_pkt[fr_txpos] : 8'h00;
                            fr_crc = crc16_byte(fr_crc, r.tx_byte);
                            fr_txpos++;
                            if (fr_txpos > int'(fr_pkt[2]) + 2 || fr_txpos >= BUF_SIZE)
                                fr_phase = PH_CRC1;
                        end
                        PH_CRC1: begin
                            r.tx_byte = fr_crc[7:0];
                            fr_phase = PH_CRC2;
                        end
                        PH_CRC2: begin
                            r.tx_byte = fr_crc[15:8];
                            fr_phase = PH_TAIL;
                        end
                        PH_TAIL: fr_phase = PH_DONE;
                        default: begin
                            r.cmd = CMD_IDLE;
                            fr_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            REQ_LOAD: begin
                if (it.idx < MAX_PAYLOAD) begin
                    fr_pkt[3 + it.idx] = it.din;
                    fr_wr[3 + it.idx] = 1'b1;
                end else begin
                    acted = 1'b0;
                end
            end
            REQ_SEND: begin
                ln = (it.len > MAX_PAYLOAD) ? 7'(MAX_PAYLOAD) : it.len;
                fr_pkt[2] = {1'b0, ln};
                fr_pkt[1] = it.hdr[6] ? it.hdr : {it.hdr[7:5], fr_node};
                fr_wr[1] = 1'b1;
                fr_wr[2] = 1'b1;
                fr_crc = crc16_byte(16'hFFFF, fr_group);
                fr_phase = PH_PRE1;
                r.cmd = CMD_TX;
            end
            REQ_RXON: begin
                open_receive();
                r.cmd = CMD_RX;
            end
            REQ_POLL: begin
                if (fr_phase == PH_RECV && rx_full()) begin
                    h = fr_pkt[1];
                    fr_phase = PH_IDLE;
                    if (fr_pkt[2] > MAX_PAYLOAD)
                        fr_crc = 16'd1;
                    if (!h[6] || fr_node == NODE_ALL || h[4:0] == fr_node)
                        r.flag = 1'b1;
                end
                if (!r.flag && fr_phase == PH_IDLE) begin
                    open_receive();
                    r.cmd = CMD_RX;
                end else if (!r.flag) begin
                    acted = 1'b0;
                end
            end
            REQ_CLAIM: begin
                if (fr_phase == PH_RECV && fr_fill == 0) begin
                    r.cmd = CMD_IDLE;
                    fr_phase = PH_IDLE;
                    r.flag = 1'b1;
                end else begin
                    acted = 1'b0;
                end
            end
            REQ_READ: begin
                if (it.idx < BUF_SIZE)
                    r.rd_byte = fr_pkt[it.idx];
            end
            default: acted = 1'b0;
        endcase
        r.crc = fr_crc;
        r.fill = 7'(fr_fill);
        return r;
    endfunction

    // longest payload run from index 0 that has been loaded
    function automatic int loaded_run();
        int n;
        n = 0;
        while (n < MAX_PAYLOAD && fr_wr[3 + n])
            n++;
        return n;
    endfunction

    function automatic logic [6:0] pick_len();
        int m;
        int r;
        m = loaded_run();
        r = $urandom_range(0, 9);
        if (r < 7)
            return 7'($urandom_range(0, (m < 8) ? m : 8));
        if (r < 9 || m < MAX_PAYLOAD)
            return 7'($urandom_range(0, m));
        return 7'($urandom_range(MAX_PAYLOAD + 1, 127));
    endfunction

    // never read an entry that has not been written
    function automatic logic [6:0] pick_read_idx();
        int k;
        if ($urandom_range(0, 15) == 0)
            return 7'($urandom_range(BUF_SIZE, 127));
        for (int t = 0; t < 30; t++) begin
            k = $urandom_range(0, BUF_SIZE - 1);
            if (fr_wr[k])
                return 7'(k);
        end
        return 7'd127;
    endfunction

    function automatic frame_req_t rand_item(input logic [2:0] req);
        frame_req_t it;
        it.req = req;
        it.din = 8'($urandom);
        it.idx = 7'($urandom);
        it.hdr = 8'($urandom);
        it.len = 7'($urandom);
        if (req == REQ_READ)
            it.idx = pick_read_idx();
        if (req == REQ_SEND)
            it.len = pick_len();
        return it;
    endfunction

    task automatic issue(input frame_req_t it, input bit typed, input frame_res_t want);
        int gap;
        bit acted;
        frame_res_t r;
        if ($urandom_range(0, 49) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= it.req;
        i_byte_in  <= it.din;
        i_index    <= it.idx;
        i_header   <= it.hdr;
        i_length   <= it.len;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = calc_framer_result(it, acted);
        radio_out_q.push_back(typed ? want : r);
        if (acted)
            n_acted++;
    endtask

    task automatic go(input frame_req_t it);
        issue(it, 1'b0, '0);
    endtask

    task automatic set_config(input logic [4:0] node, input logic [7:0] grp);
        i_valid <= 1'b0;
        while (radio_out_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NODE;
        i_cfg_data <= {3'b000, node};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GROUP;
        i_cfg_data <= grp;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fr_node = node;
        fr_group = grp;
    endtask

    task automatic rx_packet();
        logic [7:0]  bytes [$];
        logic [7:0]  h;
        logic [7:0]  ln;
        logic [15:0] c;
        int          r;
        int          cut;
        frame_req_t  it;
        if (fr_phase == PH_IDLE && $urandom_range(0, 1) == 1)
            go(rand_item(REQ_POLL));
        else
            go(rand_item(REQ_RXON));
        c = (fr_group != 8'h00) ? crc16_byte(16'hFFFF, fr_group) : 16'hFFFF;
        // without a group the group byte comes over the air as data
        if (fr_group == 8'h00)
            bytes.push_back(8'($urandom));
        h = 8'($urandom);
        case ($urandom_range(0, 2))
            0: h[6] = 1'b0;
            1: begin
                h[6] = 1'b1;
                h[4:0] = fr_node;
            end
            default: h[6] = 1'b1;
        endcase
        bytes.push_back(h);
        r = $urandom_range(0, 29);
        if (r == 0)
            ln = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        else if (r < 5)
            ln = 8'($urandom_range(0, MAX_PAYLOAD));
        else
            ln = 8'($urandom_range(0, 6));
        bytes.push_back(ln);
        repeat ((ln > MAX_PAYLOAD) ? MAX_PAYLOAD : ln)
            bytes.push_back(8'($urandom));
        foreach (bytes[i])
            c = crc16_byte(c, bytes[i]);
        if ($urandom_range(0, 3) != 0) begin
            bytes.push_back(c[7:0]);
            bytes.push_back(c[15:8]);
        end else begin
            bytes.push_back(8'($urandom));
            bytes.push_back(8'($urandom));
        end
        cut = bytes.size();
        if ($urandom_range(0, 7) == 0)
            cut = $urandom_range(0, bytes.size() - 1);
        for (int i = 0; i < cut; i++) begin
            it = rand_item(REQ_EVENT);
            it.din = bytes[i];
            go(it);
        end
        repeat ($urandom_range(0, 2)) go(rand_item(REQ_EVENT));
        if ($urandom_range(0, 7) != 0)
            go(rand_item(REQ_POLL));
        repeat ($urandom_range(0, 3)) go(rand_item(REQ_READ));
    endtask

    task automatic tx_packet();
        frame_req_t it;
        int k;
        int total;
        int cut;
        if ($urandom_range(0, 1) == 1) begin
            go(rand_item(REQ_RXON));
            go(rand_item(REQ_CLAIM));
        end
        k = ($urandom_range(0, 19) == 0) ? MAX_PAYLOAD : $urandom_range(0, 8);
        for (int i = 0; i < k; i++) begin
            it = rand_item(REQ_LOAD);
            it.idx = 7'(i);
            go(it);
        end
        if ($urandom_range(0, 3) == 0)
            go(rand_item(REQ_LOAD));
        it = rand_item(REQ_SEND);
        go(it);
        // preamble, sync, group, header, length, payload, crc, tail, last byte
        total = ((it.len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(it.len)) + 11;
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
        repeat (cut) go(rand_item(REQ_EVENT));
    endtask

    initial begin : stim
        logic [4:0] node;
        logic [7:0] grp;
        int target;
        int sel;
        fr_node = 5'd0;
        fr_group = GROUP_RESET;
        fr_phase = PH_IDLE;
        fr_fill = 0;
        fr_crc = CRC_INIT;
        fr_txpos = 0;
        foreach (fr_pkt[i]) begin
            fr_pkt[i] = 8'h00;
            fr_wr[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIR_ROWS[i])
            issue(DIR_ROWS[i].it, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        for (int p = 0; p < 7; p++) begin
            node = NODE_PLAN[p];
            grp = GROUP_PLAN[p];
            if (p == 3 || p == 5)
                node = 5'($urandom);
            if (p == 3)
                grp = 8'($urandom);
            set_config(node, grp);
            target = n_acted + ITEMS_PER_PHASE;
            while (n_acted < target) begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    rx_packet();
                else if (sel < 75)
                    tx_packet();
                else
                    go(rand_item(3'($urandom_range(0, 7))));
            end
        end
        i_valid <= 1'b0;
        while (radio_out_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    task automatic report(input string what, input frame_res_t want, input frame_res_t got);
        n_fail++;
        if (n_fail <= 10)
            $display("%s: exp tx %h/%b cmd %0d flag %b crc %h rd %h fill %0d, got tx %h/%b cmd %0d flag %b crc %h rd %h fill %0d",
                     what, want.tx_byte, want.tx_valid, want.cmd, want.flag, want.crc,
                     want.rd_byte, want.fill, got.tx_byte, got.tx_valid, got.cmd,
                     got.flag, got.crc, got.rd_byte, got.fill);
    endtask

    initial begin : sink
        int gap;
        frame_res_t got;
        frame_res_t want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 49) == 0)
                rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got = '{o_tx_byte, o_tx_valid, o_radio_cmd, o_flag, o_crc_value, o_read_byte,
                    o_fill_count};
            if (radio_out_q.size() == 0) begin
                report("unexpected transaction", '0, got);
            end else begin
                want = radio_out_q.pop_front();
                if (got !== want)
                    report("mismatch", want, got);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rpf_pkg.sv
rtl/rpf_ram.sv
rtl/radio_packet_framer_crc16_unit.sv
rtl/rpf_checker.sv
verif/tb_top.sv
